FILE: rtl/core/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// wavhp_pkg
// Types and constants shared by the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] MIN_LENGTH = 32'd44;
	localparam logic [31:0] SCAN_POS   = 32'd15;	// scan start plus three tag bytes

	// offsets inside the fmt chunk, counted from the first tag byte
	localparam logic [31:0] FMT_CH_LO   = 32'd10;
	localparam logic [31:0] FMT_CH_HI   = 32'd11;
	localparam logic [31:0] FMT_RATE_0  = 32'd12;
	localparam logic [31:0] FMT_RATE_3  = 32'd15;
	localparam logic [31:0] FMT_BITS_LO = 32'd22;
	localparam logic [31:0] FMT_BITS_HI = 32'd23;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	localparam logic [3:0] ST_OK      = 4'd0;
	localparam logic [3:0] ST_SHORT   = 4'd1;
	localparam logic [3:0] ST_NO_RIFF = 4'd2;
	localparam logic [3:0] ST_NO_WAVE = 4'd3;
	localparam logic [3:0] ST_NO_FMT  = 4'd4;
	localparam logic [3:0] ST_NO_DATA = 4'd5;
	localparam logic [3:0] ST_OVERRUN = 4'd6;
	localparam logic [3:0] ST_BAD_BITS = 4'd7;
	localparam logic [3:0] ST_ORDER   = 4'd8;

	typedef struct packed {
		logic        run_last;
		logic [1:0]  item_kind;
		logic [3:0]  status;
		logic [31:0] data_bytes;
		logic [31:0] rate_hz;
		logic [1:0]  format_code;
		logic [15:0] sample_value;
	} result_t;

	function automatic result_t make_result(input logic [1:0] kind, input logic [15:0] sample,
		input logic [1:0] fmt, input logic [31:0] rate, input logic [31:0] len,
		input logic [3:0] st);
		result_t r;
		r.run_last     = 1'b0;
		r.item_kind    = kind;
		r.status       = st;
		r.data_bytes   = len;
		r.rate_hz      = rate;
		r.format_code  = fmt;
		r.sample_value = sample;
		return r;
	endfunction

endpackage

FILE: rtl/core/wav_header_parse_and_sample_swap_top.sv
// ----------------------------------------------------------------------------
// wav_header_parse_and_sample_swap_top
// Parses a RIFF/WAVE byte stream, reports the format and passes samples.
// ----------------------------------------------------------------------------
// A result beat is written into the result queue when the input byte that causes it is accepted.
// Throughput: one input byte per cycle; the final byte of a file can give two
// result beats, which drain through a four-entry result queue, one beat a cycle while m_tready is high.
// Input is accepted while the queue has room for two beats.
// Reset: asynchronous, clears the parse state and file_length to zero and empties the queue.
module wav_header_parse_and_sample_swap_top
	import wavhp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,		// file_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,		// file_byte
	input  logic        s_tlast,		// is_final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,		// sample_value, format_code, rate_hz, data_bytes, status, pad
	output logic [1:0]  m_tuser,		// item_kind
	output logic        m_tlast			// run_last
);

	localparam int QDEPTH = 4;
	localparam int PW = $clog2(QDEPTH);

	logic [31:0] flen_q;
	logic [31:0] pos_q, pos_d;
	logic [31:0] tw_q, tw_d;
	logic        fmt_seen_q, fmt_seen_d;
	logic [31:0] fmt_start_q, fmt_start_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] brem_q, brem_d;
	logic [7:0]  held_q, held_d;
	logic        phase_q, phase_d;
	logic [3:0]  err_q, err_d;
	logic [2:0]  lleft_q, lleft_d;
	logic        rep_q, rep_d;

	result_t     queue_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	result_t     prim, res0, res1;
	logic        prim_vld;
	logic [1:0]  nres;
	logic        acc, pop;
	logic [31:0] fdist, dist_fin;
	logic [32:0] end_pos;
	logic        in_scan, fmt_done_fin;
	logic [1:0]  fcode;
	logic [4:0]  rshift;

	assign cfg_ready = 1'b1;
	assign acc = s_tvalid && s_tready;
	assign pop = m_tvalid && m_tready;
	assign s_tready = cnt_q <= (PW+1)'(QDEPTH - 2);

	assign fdist   = pos_q - fmt_start_q;
	assign in_scan = ({1'b0, pos_q} + 33'd5) < {1'b0, flen_q};
	assign rshift  = {fdist[1:0], 3'b000};
	assign fcode   = {bits_q == 16'd16, chan_q == 16'd2};

	always_comb begin
		pos_d = pos_q; tw_d = {tw_q[23:0], s_tdata};
		fmt_seen_d = fmt_seen_q; fmt_start_d = fmt_start_q;
		chan_d = chan_q; rate_d = rate_q; bits_d = bits_q;
		brem_d = brem_q; held_d = held_q; phase_d = phase_q;
		err_d = err_q; lleft_d = lleft_q; rep_d = rep_q;
		prim = make_result(KIND_SAMPLE, 16'd0, 2'd0, 32'd0, 32'd0, ST_OK);
		prim_vld = 1'b0;
		end_pos = '0;
		if (!rep_q) begin
			priority if (pos_q == 32'd0 && flen_q < MIN_LENGTH) begin
				err_d = ST_SHORT; rep_d = 1'b1; prim_vld = 1'b1;
			end else if (pos_q == 32'd3 && tw_d != TAG_RIFF) begin
				err_d = ST_NO_RIFF; rep_d = 1'b1; prim_vld = 1'b1;
			end else if (pos_q == 32'd11 && tw_d != TAG_WAVE) begin
				err_d = ST_NO_WAVE; rep_d = 1'b1; prim_vld = 1'b1;
			end else if (lleft_q != 3'd0) begin
				brem_d  = {s_tdata, brem_q[31:8]};
				lleft_d = lleft_q - 3'd1;
				end_pos = {1'b0, pos_q} + 33'd1 + {1'b0, brem_d};
				if (lleft_q == 3'd1) begin
					rep_d = 1'b1;
					prim_vld = 1'b1;
					priority if (rate_q == 32'd0) err_d = ST_NO_FMT;
					else if (end_pos > {1'b0, flen_q}) err_d = ST_OVERRUN;
					else if (bits_q != 16'd8 && bits_q != 16'd16) err_d = ST_BAD_BITS;
					else prim = make_result(KIND_REPORT, 16'd0, fcode, rate_q, brem_d, ST_OK);
				end
			end else if (pos_q >= SCAN_POS) begin
				if (fmt_seen_q) begin
					if (fdist == FMT_CH_LO) chan_d[7:0] = s_tdata;
					else if (fdist == FMT_CH_HI) chan_d[15:8] = s_tdata;
					else if (fdist >= FMT_RATE_0 && fdist <= FMT_RATE_3)
						rate_d = rate_q | ({24'd0, s_tdata} << rshift);
					else if (fdist == FMT_BITS_LO) bits_d[7:0] = s_tdata;
					else if (fdist == FMT_BITS_HI) bits_d[15:8] = s_tdata;
				end
				if (!fmt_seen_q && tw_d == TAG_FMT && in_scan) begin
					fmt_seen_d = 1'b1;
					fmt_start_d = pos_q - 32'd3;
					chan_d = '0; rate_d = '0; bits_d = '0;
				end else if (tw_d == TAG_DATA && in_scan) begin
					if (!(fmt_seen_q && fdist >= FMT_BITS_HI)) begin
						err_d = ST_ORDER; rep_d = 1'b1; prim_vld = 1'b1;
					end else begin
						lleft_d = 3'd4;
						brem_d = '0;
					end
				end
			end
		end else if (err_q == ST_OK && brem_q != 32'd0) begin
			brem_d = brem_q - 32'd1;
			if (bits_q == 16'd16) begin
				if (!phase_q) begin
					held_d = s_tdata;
					phase_d = 1'b1;
				end else begin
					phase_d = 1'b0;
					prim_vld = 1'b1;
					prim = make_result(KIND_SAMPLE, {s_tdata, held_q}, 2'd0, 32'd0, 32'd0,
						ST_OK);
				end
			end else begin
				prim_vld = 1'b1;
				prim = make_result(KIND_SAMPLE, {8'd0, s_tdata}, 2'd0, 32'd0, 32'd0, ST_OK);
			end
		end
		// a failure report carries only its status
		if (prim_vld && prim.item_kind == KIND_SAMPLE && rep_d && !rep_q)
			prim = make_result(KIND_REPORT, 16'd0, 2'd0, 32'd0, 32'd0, err_d);

		dist_fin = pos_q - fmt_start_d;
		fmt_done_fin = fmt_seen_d && dist_fin >= FMT_BITS_HI;
		res0 = prim;
		res1 = make_result(KIND_END, 16'd0, 2'd0, 32'd0, 32'd0, err_d);
		nres = {1'b0, prim_vld};
		if (s_tlast) begin
			if (!rep_d) begin
				err_d = (fmt_done_fin && rate_d != 32'd0) ? ST_NO_DATA : ST_NO_FMT;
				res0 = make_result(KIND_REPORT, 16'd0, 2'd0, 32'd0, 32'd0, err_d);
				res1.status = err_d;
				nres = 2'd2;
			end else if (prim_vld) begin
				nres = 2'd2;
			end else begin
				res0 = res1;
				nres = 2'd1;
			end
			// start over for the next file
			pos_d = '0; tw_d = '0; fmt_seen_d = 1'b0; fmt_start_d = '0;
			chan_d = '0; rate_d = '0; bits_d = '0; brem_d = '0; held_d = '0;
			phase_d = 1'b0; err_d = ST_OK; lleft_d = '0; rep_d = 1'b0;
		end else if (pos_q != 32'hFFFF_FFFF) begin
			pos_d = pos_q + 32'd1;
		end
		if (nres == 2'd2) res1.run_last = 1'b1;
		else res0.run_last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q <= '0;
			pos_q <= '0; tw_q <= '0; fmt_seen_q <= 1'b0; fmt_start_q <= '0;
			chan_q <= '0; rate_q <= '0; bits_q <= '0; brem_q <= '0; held_q <= '0;
			phase_q <= 1'b0; err_q <= ST_OK; lleft_q <= '0; rep_q <= 1'b0;
		end else begin
			if (cfg_valid) flen_q <= cfg_data;
			if (acc) begin
				pos_q <= pos_d; tw_q <= tw_d; fmt_seen_q <= fmt_seen_d;
				fmt_start_q <= fmt_start_d; chan_q <= chan_d; rate_q <= rate_d;
				bits_q <= bits_d; brem_q <= brem_d; held_q <= held_d;
				phase_q <= phase_d; err_q <= err_d; lleft_q <= lleft_d; rep_q <= rep_d;
			end
		end
	end

	// result queue: up to two beats in, one beat out per cycle
	always_ff @(posedge clk) begin
		if (acc && nres != 2'd0) queue_q[wp_q] <= res0;
		if (acc && nres == 2'd2) queue_q[wp_q + PW'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) wp_q <= wp_q + PW'(nres);
			if (pop) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + (acc ? (PW+1)'(nres) : '0) - (pop ? (PW+1)'(1) : '0);
		end
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = {2'd0, queue_q[rp_q].status, queue_q[rp_q].data_bytes,
		queue_q[rp_q].rate_hz, queue_q[rp_q].format_code, queue_q[rp_q].sample_value};
	assign m_tuser  = queue_q[rp_q].item_kind;
	assign m_tlast  = queue_q[rp_q].run_last;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(QDEPTH))
		else $error("result queue over capacity");
	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> pos_q == 32'd0 && !rep_q && lleft_q == 3'd0)
		else $error("parse state not cleared after final byte");
	a_final_marker: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> m_tvalid)
		else $error("no end marker pending after final byte");
	a_len_read: assert property (@(posedge clk) disable iff (!arst_n)
		lleft_q != 3'd0 |-> !rep_q && fmt_seen_q)
		else $error("data length read without fmt or after report");
`endif

endmodule

FILE: tb/tb_wav_header_parse_and_sample_swap_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wav_header_parse_and_sample_swap_top
// Streams RIFF/WAVE files byte by byte into the parser and checks every
// result beat against an in-bench parser model: header checks, report
// errors, sample pass-through and word swap, and end of file markers.
// Directed files come first, then random files under three idle patterns.
// ----------------------------------------------------------------------------
module tb_wav_header_parse_and_sample_swap_top
	import wavhp_pkg::*;
();

	localparam logic [31:0] TAG_LIST = 32'h4C49_5354;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;		// sample_value, format_code, rate_hz, data_bytes, status, pad
	logic [1:0]  m_tuser;		// item_kind
	logic        m_tlast;		// run_last

	wav_header_parse_and_sample_swap_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// parser model state
	logic [31:0] flen = '0;
	logic [31:0] rx_pos;
	logic [31:0] win;
	logic        fmt_seen;
	logic [31:0] fmt_base;
	logic [15:0] chans;
	logic [31:0] rate;
	logic [15:0] bits;
	logic [31:0] remain;
	logic [7:0]  low_byte;
	logic        odd_phase;
	logic [3:0]  err_code;
	logic [2:0]  len_left;
	logic        reported;

	result_t     step_beats[$];
	result_t     parse_out_q[$];
	logic [7:0]  file_q[$];

	int          err_count = 0;
	int          sent_bytes = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_request = 0;
	int          hold_left = 0;

	function automatic void clear_parse();
		rx_pos = '0; win = '0; fmt_seen = 1'b0; fmt_base = '0; chans = '0; rate = '0;
		bits = '0; remain = '0; low_byte = '0; odd_phase = 1'b0; err_code = ST_OK;
		len_left = '0; reported = 1'b0;
	endfunction

	function automatic result_t beat(input logic [1:0] kind, input logic [15:0] sample,
		input logic [1:0] fmt, input logic [31:0] rt, input logic [31:0] len,
		input logic [3:0] st);
		result_t r;
		r = '0;
		r.item_kind = kind;
		r.sample_value = sample;
		r.format_code = fmt;
		r.rate_hz = rt;
		r.data_bytes = len;
		r.status = st;
		return r;
	endfunction

	function automatic void raise_error(input logic [3:0] code);
		err_code = code;
		reported = 1'b1;
		step_beats.push_back(beat(KIND_REPORT, '0, '0, '0, '0, code));
	endfunction

	function automatic bit fmt_ready(input logic [31:0] p);
		return fmt_seen && ((p - fmt_base) >= FMT_BITS_HI);
	endfunction

	function automatic bit in_scan(input logic [31:0] p);
		return (64'(p) - 64'd3 + 64'd8) < 64'(flen);
	endfunction

	// Work out the result beats that one accepted byte causes.
	function automatic void parse_byte(input logic [7:0] b, input logic fin);
		logic [31:0] p;
		logic [31:0] d;
		logic [63:0] chunk_end;
		p = rx_pos;
		step_beats.delete();
		win = {win[23:0], b};
		if (!reported) begin
			if (p == 0 && flen < MIN_LENGTH) begin
				raise_error(ST_SHORT);
			end else if (p == 3 && win != TAG_RIFF) begin
				raise_error(ST_NO_RIFF);
			end else if (p == 11 && win != TAG_WAVE) begin
				raise_error(ST_NO_WAVE);
			end else if (len_left != 0) begin
				remain = {b, remain[31:8]};
				len_left = len_left - 3'd1;
				if (len_left == 0) begin
					chunk_end = 64'(p) + 64'd1 + 64'(remain);
					if (rate == 0) begin
						raise_error(ST_NO_FMT);
					end else if (chunk_end > 64'(flen)) begin
						raise_error(ST_OVERRUN);
					end else if (bits != 16'd8 && bits != 16'd16) begin
						raise_error(ST_BAD_BITS);
					end else begin
						reported = 1'b1;
						step_beats.push_back(beat(KIND_REPORT, '0,
							{bits == 16'd16, chans == 16'd2}, rate, remain, ST_OK));
					end
				end
			end else if (p >= SCAN_POS) begin
				if (fmt_seen) begin
					d = p - fmt_base;
					if (d == FMT_CH_LO)
						chans[7:0] = b;
					else if (d == FMT_CH_HI)
						chans[15:8] = b;
					else if (d >= FMT_RATE_0 && d <= FMT_RATE_3)
						rate = rate | (32'(b) << (8 * (d - FMT_RATE_0)));
					else if (d == FMT_BITS_LO)
						bits[7:0] = b;
					else if (d == FMT_BITS_HI)
						bits[15:8] = b;
				end
				if (!fmt_seen && win == TAG_FMT && in_scan(p)) begin
					fmt_seen = 1'b1;
					fmt_base = p - 3;
					chans = '0; rate = '0; bits = '0;
				end else if (win == TAG_DATA && in_scan(p)) begin
					if (!fmt_ready(p)) begin
						raise_error(ST_ORDER);
					end else begin
						len_left = 3'd4;
						remain = '0;
					end
				end
			end
		end else if (err_code == ST_OK && remain != 0) begin
			remain = remain - 1;
			if (bits == 16'd16) begin
				// hold the low byte, emit the swapped word on the high byte
				if (!odd_phase) begin
					low_byte = b;
					odd_phase = 1'b1;
				end else begin
					odd_phase = 1'b0;
					step_beats.push_back(beat(KIND_SAMPLE, {b, low_byte}, '0, '0, '0, ST_OK));
				end
			end else begin
				step_beats.push_back(beat(KIND_SAMPLE, {8'h00, b}, '0, '0, '0, ST_OK));
			end
		end

		if (fin) begin
			if (!reported)
				raise_error((fmt_ready(p) && rate != 0) ? ST_NO_DATA : ST_NO_FMT);
			step_beats.push_back(beat(KIND_END, '0, '0, '0, '0, err_code));
			clear_parse();
		end else if (rx_pos != '1) begin
			rx_pos = rx_pos + 1;
		end

		if (step_beats.size() > 0)
			step_beats[step_beats.size() - 1].run_last = 1'b1;
		foreach (step_beats[i])
			parse_out_q.push_back(step_beats[i]);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_count++;
		end
	endfunction

	task automatic check_beat();
		result_t want;
		if (parse_out_q.size() == 0) begin
			$error("result beat with nothing expected: kind %0d tdata 0x%0h", m_tuser, m_tdata);
			err_count++;
			return;
		end
		want = parse_out_q.pop_front();
		check_field("item_kind", 32'(want.item_kind), 32'(m_tuser));
		check_field("sample_value", 32'(want.sample_value), 32'(m_tdata[15:0]));
		check_field("format_code", 32'(want.format_code), 32'(m_tdata[17:16]));
		check_field("rate_hz", want.rate_hz, m_tdata[49:18]);
		check_field("data_bytes", want.data_bytes, m_tdata[81:50]);
		check_field("status", 32'(want.status), 32'(m_tdata[85:82]));
		check_field("run_last", 32'(want.run_last), 32'(m_tlast));
	endtask

	// result side: check accepted beats, then pick next ready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_beat();
		m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// long receiver hold-off, counted here in cycles
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left <= hold_request;
			hold_request <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		parse_byte(b, fin);
		sent_bytes++;
	endtask

	task automatic send_file();
		foreach (file_q[i])
			send_byte(file_q[i], i == file_q.size() - 1);
	endtask

	// drop valid and let the parser drain before touching the register
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (parse_out_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		flen = v;
	endtask

	function automatic void put_tag(input logic [31:0] t);
		for (int i = 3; i >= 0; i--)
			file_q.push_back(t[8*i +: 8]);
	endfunction

	function automatic void put32(input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			file_q.push_back(v[8*i +: 8]);
	endfunction

	function automatic void put16(input logic [15:0] v);
		file_q.push_back(v[7:0]);
		file_q.push_back(v[15:8]);
	endfunction

	// 44 bytes of header plus an optional junk chunk, then n_data sample bytes
	function automatic void build_file(input logic [15:0] ch, input logic [31:0] rt,
		input logic [15:0] bw, input int n_data, input logic [31:0] len_field,
		input int junk, input bit data_first);
		file_q.delete();
		put_tag(TAG_RIFF);
		put32(32'(n_data + 36));
		put_tag(TAG_WAVE);
		if (junk >= 0) begin
			put_tag(TAG_LIST);
			put32(32'(junk));
			repeat (junk) file_q.push_back(8'($urandom_range(0, 255)));
		end
		if (data_first) begin
			put_tag(TAG_DATA);
			put32(len_field);
		end
		put_tag(TAG_FMT);
		put32(32'd16);
		put16(16'd1);
		put16(ch);
		put32(rt);
		put32(rt * ch * (bw / 8));
		put16(ch * (bw / 8));
		put16(bw);
		if (!data_first) begin
			put_tag(TAG_DATA);
			put32(len_field);
		end
		repeat (n_data) file_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	task automatic test_header_checks();
		wait_idle();
		write_length(32'd0);
		file_q = '{8'h00, 8'hFF, 8'h52, 8'h49};
		send_file();

		wait_idle();
		write_length(32'd60);
		build_file(16'd1, 32'd8000, 16'd8, 16, 32'd16, -1, 1'b0);
		file_q[1] = 8'h00;
		send_file();
		build_file(16'd1, 32'd8000, 16'd8, 16, 32'd16, -1, 1'b0);
		file_q[9] = 8'hFF;
		send_file();

		// data tag ends too close to the end of a minimal file
		wait_idle();
		write_length(MIN_LENGTH);
		build_file(16'd2, 32'd44100, 16'd16, 0, 32'd0, -1, 1'b0);
		send_file();

		// fmt complete but file ends before a data tag; then fmt cut short
		wait_idle();
		write_length(32'd200);
		build_file(16'd1, 32'd22050, 16'd8, 0, 32'd0, -1, 1'b0);
		file_q = file_q[0:35];
		send_file();
		build_file(16'd1, 32'd22050, 16'd8, 0, 32'd0, -1, 1'b0);
		file_q = file_q[0:29];
		send_file();
	endtask

	task automatic test_report_errors();
		wait_idle();
		write_length(32'd60);
		build_file(16'd1, 32'd0, 16'd8, 16, 32'd16, -1, 1'b0);
		send_file();
		build_file(16'd2, 32'd48000, 16'd12, 16, 32'd16, -1, 1'b0);
		send_file();
		build_file(16'd2, 32'd48000, 16'd16, 16, 32'd17, -1, 1'b0);
		send_file();
		build_file(16'd1, 32'd48000, 16'd8, 16, 32'd16, -1, 1'b1);
		send_file();
	endtask

	task automatic test_sample_paths();
		wait_idle();
		write_length(32'd48);
		build_file(16'd2, 32'hFFFF_FFFF, 16'd16, 4, 32'd4, -1, 1'b0);
		file_q[44] = 8'h00; file_q[45] = 8'hFF; file_q[46] = 8'hFF; file_q[47] = 8'h00;
		send_file();

		wait_idle();
		write_length(32'd50);
		build_file(16'd1, 32'd1, 16'd8, 6, 32'd6, -1, 1'b0);
		file_q[44] = 8'h00; file_q[45] = 8'hFF;
		send_file();

		// odd byte of 16-bit data is dropped
		wait_idle();
		write_length(32'd47);
		build_file(16'd1, 32'd16000, 16'd16, 3, 32'd3, -1, 1'b0);
		send_file();

		// trailing bytes after the data chunk, with a junk chunk up front
		wait_idle();
		write_length(32'd70);
		build_file(16'd2, 32'd11025, 16'd8, 10, 32'd5, 6, 1'b0);
		send_file();

		// largest length: no overrun possible, data never runs out
		wait_idle();
		write_length(32'hFFFF_FFFF);
		build_file(16'd1, 32'd96000, 16'd16, 12, 32'hFFFF_FF00, -1, 1'b0);
		send_file();
	endtask

	task automatic test_backpressure();
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_length(32'd124);
		hold_request <= 300;
		build_file(16'd2, 32'd44100, 16'd16, 80, 32'd80, -1, 1'b0);
		send_file();
		build_file(16'd1, 32'd8000, 16'd8, 80, 32'd80, -1, 1'b0);
		send_file();
	endtask

	task automatic random_file();
		int          tgt;
		int          base;
		int          n;
		int          junk;
		int          sel;
		logic [31:0] lf;
		logic [15:0] ch;
		logic [15:0] bw;
		logic [31:0] rt;
		tgt = (flen >= MIN_LENGTH && flen <= 200 && $urandom_range(0, 3) != 0) ?
			int'(flen) : $urandom_range(44, 110);
		ch = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
		if ($urandom_range(0, 9) == 0)
			bw = 16'($urandom_range(0, 40));
		else
			bw = $urandom_range(0, 1) ? 16'd16 : 16'd8;
		rt = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
		junk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : -1;
		base = 44 + ((junk >= 0) ? 8 + junk : 0);
		n = (tgt > base) ? tgt - base : 0;
		lf = 32'(n);
		sel = $urandom_range(0, 19);
		if (sel < 2)
			lf = $urandom_range(0, n);
		else if (sel == 2)
			lf = 32'(n) + $urandom_range(1, 50);
		else if (sel == 3)
			lf = $urandom;
		build_file(ch, rt, bw, n, lf, junk, $urandom_range(0, 29) == 0);
		sel = $urandom_range(0, 19);
		if (sel < 2) begin
			file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
		end else if (sel == 2) begin
			file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
		end else if (sel == 3) begin
			file_q.delete();
			repeat ($urandom_range(1, 48)) file_q.push_back(8'($urandom));
		end
		send_file();
	endtask

	task automatic test_random_files(input int s_pct, input int r_pct, input int n_bytes);
		int          start;
		int          sel;
		logic [31:0] len;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = sent_bytes;
		while (sent_bytes - start < n_bytes) begin
			sel = $urandom_range(0, 19);
			if (sel == 0)
				len = $urandom_range(0, 43);
			else if (sel == 1)
				len = 32'hFFFF_FFFF;
			else if (sel == 2)
				len = $urandom;
			else
				len = $urandom_range(44, 120);
			wait_idle();
			write_length(len);
			repeat ($urandom_range(1, 4)) random_file();
		end
	endtask

	initial begin
		clear_parse();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		recv_idle_pct = 61;
		test_header_checks();
		test_report_errors();
		test_sample_paths();
		test_backpressure();
		test_random_files(20, 61, 80);
		test_random_files(61, 20, 80);
		test_random_files(0, 0, 80);

		wait_idle();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("PASS wav_header_parse_and_sample_swap_top");
		else
			$display("FAIL wav_header_parse_and_sample_swap_top");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL wav_header_parse_and_sample_swap_top");
		$finish;
	end

endmodule

FILE: wav_header_parse_and_sample_swap_top.f
rtl/core/wavhp_pkg.sv
rtl/core/wav_header_parse_and_sample_swap_top.sv
tb/tb_wav_header_parse_and_sample_swap_top.sv
